@@ design/lsme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsme_pkg: shared types and constants
// Widths, memory sizes, modes and the engine state type.
// ----------------------------------------------------------------------------
package lsme_pkg;

  localparam int unsigned MAX_POINTS = 65536;
  localparam int unsigned MAX_LABELS = 262144;
  localparam int unsigned PID_W      = 16;
  localparam int unsigned NP_W       = 17;
  localparam int unsigned OFF_AW     = 17;   // offsets table: MAX_POINTS+1 entries
  localparam int unsigned OFF_DEPTH  = MAX_POINTS + 1;
  localparam int unsigned LBL_AW     = 18;
  localparam int unsigned CNT_W      = 19;
  localparam int unsigned LABEL_W    = 32;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_AW       = 1;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_ANY = 2'd1,
    MODE_ALL = 2'd2,
    MODE_SUB = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [PID_W-1:0]   pid;
    logic [PID_W-1:0]   tid;
    logic [LABEL_W-1:0] label;
    logic               has_label;
    logic               last;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_M_O0,
    ST_M_O1,
    ST_M_O2,
    ST_M_O3,
    ST_M_O4,
    ST_M_NEXT,
    ST_M_KEY,
    ST_L_O0,
    ST_L_O1,
    ST_L_O2,
    ST_L_BODY,
    ST_SRCH,
    ST_SCMP,
    ST_SDONE,
    ST_L_END,
    ST_EMIT
  } state_t;

endpackage

@@ design/lsme_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsme_front: input capture queue
// Takes words off the start/busy port and queues them for the back end.
// ----------------------------------------------------------------------------
module lsme_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire lsme_pkg::item_t       in_item,
  input  wire lsme_pkg::back_status_t bstat,
  input  wire logic                  pop,
  output logic                       busy,
  output logic                       q_valid,
  output lsme_pkg::item_t            q_item
);

  lsme_pkg::item_t             q_mem [lsme_pkg::Q_DEPTH];
  logic [lsme_pkg::Q_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [lsme_pkg::Q_AW:0]     cnt_r, cnt_nxt;
  logic                        push;

  // hold off while the queue is full or the offsets are being cleared
  assign busy    = (cnt_r == (lsme_pkg::Q_AW+1)'(lsme_pkg::Q_DEPTH)) || bstat.clearing;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem[rp_r];

  // advance pointers
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = (pop && q_valid) ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (push ? 1'b1 : 1'b0) - ((pop && q_valid) ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store word
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ design/lsme_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsme_back: store and search engine
// Owns the offset and label memories, runs appends and binary searches.
// ----------------------------------------------------------------------------
module lsme_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [lsme_pkg::NP_W-1:0]   cfg_wdata,
  input  wire logic                        q_valid,
  input  wire lsme_pkg::item_t             q_item,
  output logic                             pop,
  output lsme_pkg::back_status_t           bstat,
  output logic                             res_valid,
  output logic                             res_answer,
  output logic                             res_full
);

  lsme_pkg::state_t state_r, state_nxt;

  logic [lsme_pkg::CNT_W-1:0]   off_mem [lsme_pkg::OFF_DEPTH];
  logic [lsme_pkg::LABEL_W-1:0] lbl_mem [lsme_pkg::MAX_LABELS];

  logic [lsme_pkg::CNT_W-1:0]   off_rdata_r;
  logic [lsme_pkg::LABEL_W-1:0] lbl_rdata_r;
  logic [lsme_pkg::OFF_AW-1:0]  off_raddr, off_waddr;
  logic [lsme_pkg::CNT_W-1:0]   off_wdata;
  logic                         off_we;
  logic [lsme_pkg::LBL_AW-1:0]  lbl_raddr;
  logic                         lbl_we;

  logic [lsme_pkg::NP_W-1:0]    num_points_r;
  logic [lsme_pkg::OFF_AW-1:0]  clr_r;
  lsme_pkg::item_t              it_r;
  logic [lsme_pkg::CNT_W-1:0]   label_count_r, ws_r, we_r, s_r, e_r, mid_r, i_r, te_r;
  logic [lsme_pkg::CNT_W-1:0]   pos_r, se_r;
  logic [lsme_pkg::LABEL_W-1:0] key_r;
  logic                         hit_r, list_open_r, pv_r, decided_r, partial_r, ovf_r;
  logic [lsme_pkg::PID_W-1:0]   open_point_r;
  logic                         res_valid_r, res_answer_r, res_full_r;

  logic                         pid_ok, tgt_ok, room, s_lt_e, i_lt_te;
  logic [lsme_pkg::CNT_W:0]     sum;
  logic [lsme_pkg::CNT_W-1:0]   mid;

  assign pid_ok  = {1'b0, it_r.pid} < num_points_r;
  assign tgt_ok  = {1'b0, it_r.tid} < num_points_r;
  assign room    = label_count_r < lsme_pkg::CNT_W'(lsme_pkg::MAX_LABELS);
  assign s_lt_e  = s_r < e_r;
  assign i_lt_te = i_r < te_r;
  assign sum     = {1'b0, s_r} + {1'b0, e_r};
  assign mid     = sum[lsme_pkg::CNT_W:1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsme_pkg::ST_CLEAR:
        if (clr_r == lsme_pkg::OFF_AW'(lsme_pkg::OFF_DEPTH - 1)) state_nxt = lsme_pkg::ST_IDLE;
      lsme_pkg::ST_IDLE:
        if (q_valid) begin
          if (q_item.mode == lsme_pkg::MODE_SUB) state_nxt = lsme_pkg::ST_M_O0;
          else if (list_open_r) state_nxt = lsme_pkg::ST_L_BODY;
          else state_nxt = lsme_pkg::ST_L_O0;
        end
      lsme_pkg::ST_M_O0:   state_nxt = (pid_ok && tgt_ok) ? lsme_pkg::ST_M_O1 : lsme_pkg::ST_EMIT;
      lsme_pkg::ST_M_O1:   state_nxt = lsme_pkg::ST_M_O2;
      lsme_pkg::ST_M_O2:   state_nxt = lsme_pkg::ST_M_O3;
      lsme_pkg::ST_M_O3:   state_nxt = lsme_pkg::ST_M_O4;
      lsme_pkg::ST_M_O4:   state_nxt = lsme_pkg::ST_M_NEXT;
      lsme_pkg::ST_M_NEXT: state_nxt = i_lt_te ? lsme_pkg::ST_M_KEY : lsme_pkg::ST_EMIT;
      lsme_pkg::ST_M_KEY:  state_nxt = lsme_pkg::ST_SRCH;
      lsme_pkg::ST_L_O0:   state_nxt = pid_ok ? lsme_pkg::ST_L_O1 : lsme_pkg::ST_L_BODY;
      lsme_pkg::ST_L_O1:   state_nxt = lsme_pkg::ST_L_O2;
      lsme_pkg::ST_L_O2:   state_nxt = lsme_pkg::ST_L_BODY;
      lsme_pkg::ST_L_BODY:
        if (it_r.has_label && pv_r && it_r.mode != lsme_pkg::MODE_ADD && !decided_r)
          state_nxt = lsme_pkg::ST_SRCH;
        else
          state_nxt = lsme_pkg::ST_L_END;
      lsme_pkg::ST_SRCH:   state_nxt = s_lt_e ? lsme_pkg::ST_SCMP : lsme_pkg::ST_SDONE;
      lsme_pkg::ST_SCMP:
        state_nxt = (lbl_rdata_r == key_r) ? lsme_pkg::ST_SDONE : lsme_pkg::ST_SRCH;
      lsme_pkg::ST_SDONE:
        if (it_r.mode == lsme_pkg::MODE_SUB)
          state_nxt = hit_r ? lsme_pkg::ST_M_NEXT : lsme_pkg::ST_EMIT;
        else
          state_nxt = lsme_pkg::ST_L_END;
      lsme_pkg::ST_L_END:  state_nxt = lsme_pkg::ST_IDLE;
      lsme_pkg::ST_EMIT:   state_nxt = lsme_pkg::ST_IDLE;
      default:             state_nxt = lsme_pkg::ST_IDLE;
    endcase
  end

  // memory ports and handshake outputs
  always_comb begin
    pop       = 1'b0;
    off_raddr = '0;
    off_we    = 1'b0;
    off_waddr = clr_r;
    off_wdata = '0;
    lbl_raddr = '0;
    lbl_we    = 1'b0;
    unique case (state_r)
      lsme_pkg::ST_CLEAR: off_we = 1'b1;
      lsme_pkg::ST_IDLE:  pop = q_valid;
      lsme_pkg::ST_M_O0, lsme_pkg::ST_L_O0:
        off_raddr = {1'b0, it_r.pid};
      lsme_pkg::ST_M_O1, lsme_pkg::ST_L_O1:
        off_raddr = {1'b0, it_r.pid} + 1'b1;
      lsme_pkg::ST_M_O2:  off_raddr = {1'b0, it_r.tid};
      lsme_pkg::ST_M_O3:  off_raddr = {1'b0, it_r.tid} + 1'b1;
      lsme_pkg::ST_M_NEXT: lbl_raddr = i_r[lsme_pkg::LBL_AW-1:0];
      lsme_pkg::ST_SRCH:  lbl_raddr = mid[lsme_pkg::LBL_AW-1:0];
      lsme_pkg::ST_L_BODY:
        lbl_we = it_r.has_label && pv_r && it_r.mode == lsme_pkg::MODE_ADD && room;
      lsme_pkg::ST_L_END: begin
        off_we    = it_r.last && it_r.mode == lsme_pkg::MODE_ADD && pv_r;
        off_waddr = {1'b0, open_point_r} + 1'b1;
        off_wdata = label_count_r;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    off_rdata_r <= off_mem[off_raddr];
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
  end

  always_ff @(posedge clk) begin
    lbl_rdata_r <= lbl_mem[lbl_raddr];
    if (lbl_we) begin
      lbl_mem[label_count_r[lsme_pkg::LBL_AW-1:0]] <= it_r.label;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lsme_pkg::ST_CLEAR;
      clr_r         <= '0;
      num_points_r  <= '0;
      label_count_r <= '0;
      list_open_r   <= 1'b0;
      pv_r          <= 1'b0;
      decided_r     <= 1'b0;
      partial_r     <= 1'b0;
      ovf_r         <= 1'b0;
      open_point_r  <= '0;
      ws_r          <= '0;
      we_r          <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= 1'b0;
      if (cfg_we) num_points_r <= cfg_wdata;
      if (state_r == lsme_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (lbl_we) label_count_r <= label_count_r + 1'b1;
      unique case (state_r)
        lsme_pkg::ST_L_O0: begin
          list_open_r  <= 1'b1;
          open_point_r <= it_r.pid;
          pv_r         <= pid_ok;
          decided_r    <= 1'b0;
          partial_r    <= (it_r.mode == lsme_pkg::MODE_ALL);
          ovf_r        <= 1'b0;
          ws_r         <= '0;
          we_r         <= '0;
        end
        lsme_pkg::ST_L_O1: ws_r <= off_rdata_r;
        lsme_pkg::ST_L_O2: we_r <= off_rdata_r;
        lsme_pkg::ST_L_BODY:
          if (it_r.has_label && pv_r && it_r.mode == lsme_pkg::MODE_ADD && !room) ovf_r <= 1'b1;
        lsme_pkg::ST_SDONE:
          if (it_r.mode != lsme_pkg::MODE_SUB) begin
            ws_r <= pos_r;
            if (it_r.mode == lsme_pkg::MODE_ANY && hit_r) begin
              decided_r <= 1'b1;
              partial_r <= 1'b1;
            end else if (it_r.mode == lsme_pkg::MODE_ALL && !hit_r) begin
              decided_r <= 1'b1;
              partial_r <= 1'b0;
            end
          end
        lsme_pkg::ST_L_END:
          if (it_r.last) begin
            list_open_r <= 1'b0;
            ovf_r       <= 1'b0;
            res_valid_r <= 1'b1;
          end
        lsme_pkg::ST_EMIT: res_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers; offset reads land one state after their address
  always_ff @(posedge clk) begin
    case (state_r)
      lsme_pkg::ST_IDLE:  if (q_valid) it_r <= q_item;
      lsme_pkg::ST_M_O0: begin
        res_answer_r <= 1'b0;
        res_full_r   <= 1'b0;
      end
      lsme_pkg::ST_M_O1:  s_r  <= off_rdata_r;
      lsme_pkg::ST_M_O2:  se_r <= off_rdata_r;
      lsme_pkg::ST_M_O3:  i_r  <= off_rdata_r;
      lsme_pkg::ST_M_O4:  te_r <= off_rdata_r;
      lsme_pkg::ST_M_NEXT: if (!i_lt_te) res_answer_r <= 1'b1;
      lsme_pkg::ST_M_KEY: begin
        key_r <= lbl_rdata_r;
        e_r   <= se_r;
        hit_r <= 1'b0;
      end
      lsme_pkg::ST_L_BODY: begin
        s_r   <= ws_r;
        e_r   <= we_r;
        key_r <= it_r.label;
        hit_r <= 1'b0;
      end
      lsme_pkg::ST_SRCH: begin
        mid_r <= mid;
        pos_r <= s_r;
      end
      lsme_pkg::ST_SCMP:
        if (lbl_rdata_r == key_r) begin
          hit_r <= 1'b1;
          pos_r <= mid_r;
        end else if (lbl_rdata_r < key_r) begin
          s_r <= mid_r + 1'b1;
        end else begin
          e_r <= mid_r;
        end
      lsme_pkg::ST_SDONE:
        if (it_r.mode == lsme_pkg::MODE_SUB) begin
          s_r <= pos_r;
          i_r <= i_r + 1'b1;
          if (!hit_r) res_answer_r <= 1'b0;
        end
      lsme_pkg::ST_L_END: begin
        res_answer_r <= (it_r.mode == lsme_pkg::MODE_ADD) ? pv_r : (pv_r && partial_r);
        res_full_r   <= (it_r.mode == lsme_pkg::MODE_ADD) && ovf_r;
      end
      default: ;
    endcase
  end

  // drive status and result ports
  assign bstat.clearing = (state_r == lsme_pkg::ST_CLEAR);
  assign res_valid      = res_valid_r;
  assign res_answer     = res_answer_r;
  assign res_full       = res_full_r;

endmodule
`default_nettype wire

@@ design/label_set_membership_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// label_set_membership_engine: label store with sorted-list membership search
// Appends per-point label lists and answers any/all/contains queries.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  input   | in_mode in_pid in_tid in_label ...     | start && !busy
//  result  | out_answer out_store_full              | out_valid, one cycle
//  config  | cfg_we cfg_wdata                       | cfg_we
//
// A list word that opens a list first reads the point's offsets. A contains
// check reads the offsets of both points, goes straight to its result on a
// bad id and needs no search for an empty target. Each binary search takes up
// to 19 steps over a full store; a contains check runs one search per target
// label until a label is missing. The label memory has a single read port.
// After reset the offset table is cleared with busy high.
// Results cannot be stalled; a two-word queue lets start run ahead.
module label_set_membership_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [lsme_pkg::PID_W-1:0]    in_pid,
  input  wire logic [lsme_pkg::PID_W-1:0]    in_tid,
  input  wire logic [lsme_pkg::LABEL_W-1:0]  in_label,
  input  wire logic                          in_has_label,
  input  wire logic                          in_last,
  output logic                               out_valid,
  output logic                               out_answer,
  output logic                               out_store_full,
  input  wire logic                          cfg_we,
  input  wire logic [lsme_pkg::NP_W-1:0]     cfg_wdata
);

  lsme_pkg::item_t        in_item, q_item;
  lsme_pkg::back_status_t bstat;
  logic                   q_valid, pop;

  assign in_item.mode      = lsme_pkg::mode_t'(in_mode);
  assign in_item.pid       = in_pid;
  assign in_item.tid       = in_tid;
  assign in_item.label     = in_label;
  assign in_item.has_label = in_has_label;
  assign in_item.last      = in_last;

  lsme_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .bstat(bstat),
    .pop(pop), .busy(busy), .q_valid(q_valid), .q_item(q_item)
  );

  lsme_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_item(q_item), .pop(pop), .bstat(bstat),
    .res_valid(out_valid), .res_answer(out_answer), .res_full(out_store_full)
  );

endmodule
`default_nettype wire

@@ design/lsme_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsme_checker: port-level checks
// Watches the top level's ports for result and reset behavior.
// ----------------------------------------------------------------------------
module lsme_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_answer,
  input wire logic out_store_full
);

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  // reset starts the offset clear, which holds off input
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy during offset clear");

  // a full flag only comes with a valid add result
  a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_full |-> out_answer)
    else $error("store_full without valid add result");

  // results are single-cycle strobes with an engine pass between them
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back results");

endmodule

bind label_set_membership_engine lsme_checker u_lsme_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_answer(out_answer), .out_store_full(out_store_full)
);
`default_nettype wire
